// ===== sv/hg_phase_evaluate_assert.svh =====
`ifndef HG_PHASE_EVALUATE_ASSERT_SVH
`define HG_PHASE_EVALUATE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HG_ASSERT_NEVER(lbl, expr, msg) `HG_ASSERT(lbl, !(expr), msg)
`else
`define HG_ASSERT(lbl, prop, msg)
`define HG_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== sv/hg_pkg.sv =====
`timescale 1ns / 1ps
package hg_pkg;

  typedef struct packed {
    logic signed [15:0] incoming_x;
    logic signed [15:0] incoming_y;
    logic signed [15:0] incoming_z;
    logic signed [15:0] outgoing_x;
    logic signed [15:0] outgoing_y;
    logic signed [15:0] outgoing_z;
  } in_req_t;

  typedef struct packed {
    logic [31:0] attenuation_red;
    logic [31:0] attenuation_green;
    logic [31:0] attenuation_blue;
    logic [31:0] density;
    logic        valid_res;
  } out_rsp_t;

  typedef enum logic [1:0] {
    RegAsymRed    = 2'd0,
    RegAsymGreen  = 2'd1,
    RegAsymBlue   = 2'd2,
    RegMinDensity = 2'd3
  } reg_idx_e;

  localparam int unsigned TW  = 35;
  localparam int unsigned SW  = 18;
  localparam int unsigned NKW = 57;
  localparam int unsigned DW  = 52;
  localparam int unsigned QW  = 32;

  localparam logic [28:0] InvFourPi  = 29'd341782638;
  localparam logic [33:0] RecipThree = 34'd11453246123;
  localparam logic [31:0] Max32      = 32'hFFFF_FFFF;

endpackage

// ===== sv/hg_phase_evaluate.sv =====
// throughput: one request per cycle while the pipeline is not stalled, set by the fully pipelined square root
// (one root bit per stage) and divider (one quotient bit per stage)
// a waiting result stalls the pipeline only once its last stage is occupied
// reset (rst_ni, asynchronous, active low) clears all valid bits and sets
// the asymmetry registers to 0 and min_density to 1
`timescale 1ns / 1ps
`include "hg_phase_evaluate_assert.svh"
module hg_phase_evaluate (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hg_pkg::in_req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hg_pkg::out_rsp_t out_rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic signed [33:0] OneQ28 = 34'sh1000_0000;

  logic signed [14:0] asym_q [3];
  logic [15:0]        min_density_q;
  hg_pkg::reg_idx_e   reg_idx;

  logic               pipe_en;

  logic               vld_1_q;
  logic signed [31:0] prod_q [3];

  logic               vld_2_q;
  logic signed [29:0] c_q;
  logic signed [33:0] dot_sum;
  logic signed [33:0] c_neg;
  logic signed [33:0] c_clamp;

  logic [2:0]         ch_vld;
  logic [31:0]        ch_val [3];

  logic               vld_s_q;
  logic [33:0]        sum_q;
  logic [31:0]        att_s_q [3];

  logic               vld_p_q;
  logic [31:0]        dens_p_q;
  logic [31:0]        att_p_q [3];
  logic [67:0]        dens_full;

  logic               vld_f_q;
  hg_pkg::out_rsp_t   res_f_q;

  logic               out_vld_q;
  hg_pkg::out_rsp_t   out_q;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = hg_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asym_q[0]     <= '0;
      asym_q[1]     <= '0;
      asym_q[2]     <= '0;
      min_density_q <= 16'd1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        hg_pkg::RegAsymRed:    asym_q[0]     <= pwdata[14:0];
        hg_pkg::RegAsymGreen:  asym_q[1]     <= pwdata[14:0];
        hg_pkg::RegAsymBlue:   asym_q[2]     <= pwdata[14:0];
        hg_pkg::RegMinDensity: min_density_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hg_pkg::RegAsymRed:    prdata = {17'b0, asym_q[0]};
      hg_pkg::RegAsymGreen:  prdata = {17'b0, asym_q[1]};
      hg_pkg::RegAsymBlue:   prdata = {17'b0, asym_q[2]};
      hg_pkg::RegMinDensity: prdata = {16'b0, min_density_q};
      default:               prdata = '0;
    endcase
  end

  // pipeline moves unless its last stage and the output register are both full and out_ready_i is low
  assign pipe_en    = !vld_f_q || !out_vld_q || out_ready_i;
  assign in_ready_o = pipe_en;

  always_comb begin
    dot_sum = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]);
    c_neg   = -dot_sum;
    if (c_neg > OneQ28) begin
      c_clamp = OneQ28;
    end else if (c_neg < -OneQ28) begin
      c_clamp = -OneQ28;
    end else begin
      c_clamp = c_neg;
    end
    dens_full = sum_q * hg_pkg::RecipThree;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_1_q <= 1'b0;
      vld_2_q <= 1'b0;
      vld_s_q <= 1'b0;
      vld_p_q <= 1'b0;
      vld_f_q <= 1'b0;
    end else if (pipe_en) begin
      vld_1_q <= in_valid_i;
      vld_2_q <= vld_1_q;
      vld_s_q <= &ch_vld;
      vld_p_q <= vld_s_q;
      vld_f_q <= vld_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prod_q[0] <= in_req_i.incoming_x * in_req_i.outgoing_x;
      prod_q[1] <= in_req_i.incoming_y * in_req_i.outgoing_y;
      prod_q[2] <= in_req_i.incoming_z * in_req_i.outgoing_z;
      c_q       <= c_clamp[29:0];
      sum_q     <= 34'(ch_val[0]) + 34'(ch_val[1]) + 34'(ch_val[2]);
      att_s_q   <= ch_val;
      dens_p_q  <= dens_full[66:35];
      att_p_q   <= att_s_q;
      res_f_q.attenuation_red   <= att_p_q[0];
      res_f_q.attenuation_green <= att_p_q[1];
      res_f_q.attenuation_blue  <= att_p_q[2];
      res_f_q.density           <= dens_p_q;
      res_f_q.valid_res         <= (dens_p_q >= {16'b0, min_density_q});
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ch
    hg_channel u_channel (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (vld_2_q),
      .c_i     (c_q),
      .g_i     (asym_q[i]),
      .valid_o (ch_vld[i]),
      .val_o   (ch_val[i])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= vld_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_ready_i) begin
      out_q <= res_f_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  `HG_ASSERT(a_ready_when_out_free, !out_vld_q |-> in_ready_o, "not ready with free output")
  `HG_ASSERT_NEVER(a_stall_needs_full, !pipe_en && !(vld_f_q && out_vld_q), "stall without backlog")
  `HG_ASSERT(a_density_bounded, out_valid_o |-> (out_rsp_o.density <= out_rsp_o.attenuation_red || out_rsp_o.density <= out_rsp_o.attenuation_green || out_rsp_o.density <= out_rsp_o.attenuation_blue), "density above all channels")

endmodule

// ===== sv/hg_sqrt.sv =====
`timescale 1ns / 1ps
module hg_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [hg_pkg::TW-1:0]    t_i,
  input  logic [hg_pkg::NKW-1:0]   nk_i,
  output logic                     valid_o,
  output logic [hg_pkg::TW-1:0]    t_o,
  output logic [hg_pkg::SW-1:0]    root_o,
  output logic [hg_pkg::NKW-1:0]   nk_o
);

  localparam int unsigned Steps = hg_pkg::SW;
  localparam int unsigned RemW  = hg_pkg::SW + 2;

  logic [Steps-1:0]         vld_q;
  logic [RemW-1:0]          rem_q  [Steps];
  logic [hg_pkg::SW-1:0]    root_q [Steps];
  logic [hg_pkg::TW-1:0]    t_q    [Steps];
  logic [hg_pkg::NKW-1:0]   nk_q   [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                   vld_in;
    logic [RemW-1:0]        rem_in;
    logic [hg_pkg::SW-1:0]  root_in;
    logic [hg_pkg::TW-1:0]  t_in;
    logic [hg_pkg::NKW-1:0] nk_in;
    logic [2*Steps-1:0]     rad;
    logic [RemW+1:0]        rem_sh;
    logic [RemW+1:0]        trial;
    logic [RemW+1:0]        rem_nx;
    logic                   ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign t_in    = t_i;
      assign nk_in   = nk_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign t_in    = t_q[k-1];
      assign nk_in   = nk_q[k-1];
    end

    always_comb begin
      rad    = {1'b0, t_in};
      rem_sh = {rem_in, rad[2*(Steps-1-k) +: 2]};
      trial  = {2'b00, root_in, 2'b01};
      ge     = (rem_sh >= trial);
      rem_nx = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_nx[RemW-1:0];
        root_q[k] <= {root_in[hg_pkg::SW-2:0], ge};
        t_q[k]    <= t_in;
        nk_q[k]   <= nk_in;
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign t_o     = t_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign nk_o    = nk_q[Steps-1];

endmodule

// ===== sv/hg_div.sv =====
`timescale 1ns / 1ps
module hg_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [hg_pkg::DW-1:0]    d_i,
  input  logic [hg_pkg::NKW-1:0]   nk_i,
  output logic                     valid_o,
  output logic [hg_pkg::QW-1:0]    val_o
);

  localparam int unsigned Steps = hg_pkg::QW;
  localparam int unsigned XW    = hg_pkg::NKW + 4;
  localparam int unsigned HiW   = XW - hg_pkg::QW;

  typedef struct packed {
    logic [hg_pkg::DW-1:0] d;
    logic [hg_pkg::DW-1:0] rem;
    logic [hg_pkg::QW-1:0] lo;
    logic [hg_pkg::QW-1:0] q;
    logic                  sat;
    logic                  zero;
    logic                  nz;
  } div_stage_t;

  logic [Steps:0]        vld_q;
  div_stage_t            st_q [Steps+1];
  logic                  res_vld_q;
  logic [hg_pkg::QW-1:0] res_q;

  logic [XW-1:0]  x;
  div_stage_t     init_d;

  // numerator scaled by 16, its top 29 bits seed the remainder
  always_comb begin
    x           = {nk_i, 4'b0000};
    init_d.d    = d_i;
    init_d.rem  = {{(hg_pkg::DW-HiW){1'b0}}, x[XW-1:hg_pkg::QW]};
    init_d.lo   = x[hg_pkg::QW-1:0];
    init_d.q    = '0;
    init_d.sat  = ({{(hg_pkg::DW-HiW){1'b0}}, x[XW-1:hg_pkg::QW]} >= d_i);
    init_d.zero = (d_i == '0);
    init_d.nz   = (nk_i != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= init_d;
    end
  end

  for (genvar k = 1; k <= Steps; k++) begin : g_step
    logic [hg_pkg::DW:0] rem_sh;
    logic [hg_pkg::DW:0] rem_nx;
    logic                ge;
    div_stage_t          nx;

    always_comb begin
      rem_sh = {st_q[k-1].rem, st_q[k-1].lo[hg_pkg::QW-1]};
      ge     = (rem_sh >= {1'b0, st_q[k-1].d});
      rem_nx = ge ? (rem_sh - {1'b0, st_q[k-1].d}) : rem_sh;
      nx     = st_q[k-1];
      nx.rem = rem_nx[hg_pkg::DW-1:0];
      nx.lo  = {st_q[k-1].lo[hg_pkg::QW-2:0], 1'b0};
      nx.q   = {st_q[k-1].q[hg_pkg::QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (en_i) begin
      res_vld_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (st_q[Steps].zero) begin
        res_q <= st_q[Steps].nz ? hg_pkg::Max32 : '0;
      end else if (st_q[Steps].sat) begin
        res_q <= hg_pkg::Max32;
      end else begin
        res_q <= st_q[Steps].q;
      end
    end
  end

  assign valid_o = res_vld_q;
  assign val_o   = res_q;

endmodule

// ===== sv/hg_channel.sv =====
`timescale 1ns / 1ps
module hg_channel (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [29:0]     c_i,
  input  logic signed [14:0]     g_i,
  output logic                   valid_o,
  output logic [hg_pkg::QW-1:0]  val_o
);

  localparam logic signed [46:0] OneQ42 = 47'sh400_0000_0000;
  localparam logic [28:0]        OneQ28 = 29'h1000_0000;

  logic                   vld_a_q;
  logic [28:0]            gg_q;
  logic signed [44:0]     cg_q;
  logic signed [29:0]     gg_full;

  logic                   vld_b_q;
  logic [hg_pkg::TW-1:0]  t_b_q;
  logic [hg_pkg::NKW-1:0] nk_b_q;
  logic signed [46:0]     t42;
  logic [28:0]            n_b;
  logic [57:0]            nk_full;

  logic                   sq_vld;
  logic [hg_pkg::TW-1:0]  sq_t;
  logic [hg_pkg::SW-1:0]  sq_root;
  logic [hg_pkg::NKW-1:0] sq_nk;

  logic                   vld_m_q;
  logic [hg_pkg::DW-1:0]  d_m_q;
  logic [hg_pkg::NKW-1:0] nk_m_q;
  logic [52:0]            d_full;

  assign gg_full = g_i * g_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_m_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_m_q <= sq_vld;
    end
  end

  // t in Q.42, never negative for |g| below one
  always_comb begin
    t42     = OneQ42 + $signed({4'b0000, gg_q, 14'b0})
            + $signed({cg_q[44], cg_q, 1'b0});
    n_b     = OneQ28 - gg_q;
    nk_full = n_b * hg_pkg::InvFourPi;
    d_full  = sq_t * sq_root;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gg_q   <= gg_full[28:0];
      cg_q   <= 45'(c_i * g_i);
      t_b_q  <= t42[44:10];
      nk_b_q <= nk_full[hg_pkg::NKW-1:0];
      d_m_q  <= d_full[hg_pkg::DW-1:0];
      nk_m_q <= sq_nk;
    end
  end

  hg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_b_q),
    .t_i     (t_b_q),
    .nk_i    (nk_b_q),
    .valid_o (sq_vld),
    .t_o     (sq_t),
    .root_o  (sq_root),
    .nk_o    (sq_nk)
  );

  hg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (vld_m_q),
    .d_i     (d_m_q),
    .nk_i    (nk_m_q),
    .valid_o (valid_o),
    .val_o   (val_o)
  );

endmodule
